// ===== design/xves_pkg.sv =====
// shared types and constants of the xor value stream encoder
package xves_pkg;

   // sample width and packed word width (the packer is built for full 64-bit words)
   localparam int SAMPLE_W    = 64;
   localparam int WORD_BITS   = 64;
   // width of a zero count field in the stream
   localparam int CNT_W       = 6;
   // largest bit group one sample appends: two control bits, two counts, meaningful bits
   localparam int CHUNK_W     = 2 + 2 * CNT_W + SAMPLE_W;
   // bit count of a group, up to CHUNK_W
   localparam int LEN_W       = 7;
   // result word_bits field width
   localparam int BITS_W      = 7;
   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // what the back has to do with a queued request
   typedef enum logic [1:0] {
      OP_FLUSH,
      OP_RAW,
      OP_BITS
   } op_type;

   // one queued request: bit group left aligned in chunk, nbits valid from the top
   typedef struct packed {
      op_type              op;
      logic [CHUNK_W-1:0]  chunk;
      logic [LEN_W-1:0]    nbits;
   } item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== design/xor_value_stream_encoder_core.sv =====
// top level of the xor value stream encoder
//
// Requests enter through req_push/req_full: req_value is a 64-bit sample,
// req_flush asks for the partly filled packed word. Results leave through
// rsp_empty/rsp_pop; the oldest result sits on the rsp_ ports while rsp_empty
// is low. The first sample after reset comes out raw with rsp_kind high; later
// samples are xor coded and packed MSB first into 64-bit words. rsp_last marks
// the final result of a request; flushing an empty word gives no result.
// A request passes the first front stage, the second front stage, the queue
// and the result register in that order; a full stage holds the ones before it.
// One request is taken per cycle while req_full is low. A request that
// completes two words holds the packer until its second word is registered,
// and the result port delivers one word a cycle while the receiver pops.
// Reset clears the sample history, the zero counts and the packer; the next
// sample is treated as the first one. When the receiver stalls, the result
// register holds, the four-entry queue fills and then req_full rises.
module xor_value_stream_encoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [xves_pkg::SAMPLE_W-1:0] req_value,
   input  logic                          req_flush,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [xves_pkg::SAMPLE_W-1:0] rsp_packed_word,
   output logic [xves_pkg::BITS_W-1:0]   rsp_word_bits,
   output logic                          rsp_kind,
   output logic                          rsp_last
);
   import xves_pkg::*;

   qstat_type q_stat;
   item_type  wr_item;
   item_type  rd_item;
   logic      q_push;
   logic      q_pop;

   // classification and bit group assembly
   xves_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_flush (req_flush),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (wr_item)
   );

   // decoupling queue
   xves_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .wr_item (wr_item),
      .q_pop   (q_pop),
      .rd_item (rd_item),
      .q_stat  (q_stat)
   );

   // packer and result port
   xves_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rd_item         (rd_item),
      .q_stat          (q_stat),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_word (rsp_packed_word),
      .rsp_word_bits   (rsp_word_bits),
      .rsp_kind        (rsp_kind),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== design/xves_front.sv =====
// front end: takes requests, xors with the previous sample, counts zeros, builds bit groups
module xves_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [xves_pkg::SAMPLE_W-1:0] req_value,
   input  logic                          req_flush,
   input  xves_pkg::qstat_type           q_stat,
   output logic                          q_push,
   output xves_pkg::item_type            q_item
);
   import xves_pkg::*;

   localparam logic [1:0] CTL_SAME = 2'b10;
   localparam logic [1:0] CTL_NEW  = 2'b11;
   localparam int         PAD_W    = CHUNK_W - SAMPLE_W;

   // leading zero count by halving search, six narrow steps
   function automatic logic [CNT_W-1:0] lead_zeros(input logic [SAMPLE_W-1:0] x);
      logic [SAMPLE_W-1:0] v;
      logic [CNT_W-1:0]    n;
      v = x;
      n = '0;
      for (int k = CNT_W - 1; k >= 0; k--) begin
         if ((v >> (SAMPLE_W - (1 << k))) == '0) begin
            n[k] = 1'b1;
            v    = v << (1 << k);
         end
      end
      return n;
   endfunction

   function automatic logic [SAMPLE_W-1:0] bit_rev(input logic [SAMPLE_W-1:0] x);
      logic [SAMPLE_W-1:0] r;
      for (int i = 0; i < SAMPLE_W; i++) begin
         r[i] = x[SAMPLE_W-1-i];
      end
      return r;
   endfunction

   logic                started_ff, started_in;
   logic [SAMPLE_W-1:0] prev_sample_ff, prev_sample_in;
   logic [CNT_W-1:0]    prev_lead_ff, prev_lead_in;
   logic [CNT_W-1:0]    prev_trail_ff, prev_trail_in;

   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff, s1_op_in;
   logic [SAMPLE_W-1:0] s1_data_ff, s1_data_in;

   logic                s2_valid_ff, s2_valid_in;
   op_type              s2_op_ff, s2_op_in;
   logic [SAMPLE_W-1:0] s2_data_ff, s2_data_in;
   logic [CNT_W-1:0]    s2_lead_ff, s2_lead_in;
   logic [CNT_W-1:0]    s2_tail_ff, s2_tail_in;
   logic                s2_zero_ff, s2_zero_in;

   logic                s2_move, s2_load, s1_move, s1_load, accept;
   logic                new_counts, same_counts;
   logic [SAMPLE_W-1:0] aligned;
   logic [LEN_W-1:0]    mlen;

   // stage handshake, ready ripples back from the queue
   assign s2_move  = s2_valid_ff && !q_stat.full;
   assign s2_load  = !s2_valid_ff || s2_move;
   assign s1_move  = s1_valid_ff && s2_load;
   assign s1_load  = !s1_valid_ff || s1_move;
   assign req_full = !s1_load;
   assign accept   = req_push && s1_load;

   // sample history and request classification
   always_comb begin
      started_in     = started_ff;
      prev_sample_in = prev_sample_ff;
      s1_valid_in    = s1_valid_ff;
      s1_op_in       = s1_op_ff;
      s1_data_in     = s1_data_ff;
      if (s1_load) begin
         s1_valid_in = accept;
      end
      if (accept) begin
         if (req_flush) begin
            s1_op_in   = OP_FLUSH;
            s1_data_in = '0;
         end else if (!started_ff) begin
            s1_op_in       = OP_RAW;
            s1_data_in     = req_value;
            started_in     = 1'b1;
            prev_sample_in = req_value;
         end else begin
            s1_op_in       = OP_BITS;
            s1_data_in     = prev_sample_ff ^ req_value;
            prev_sample_in = req_value;
         end
      end
   end

   // zero counts of the xor
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_op_in    = s2_op_ff;
      s2_data_in  = s2_data_ff;
      s2_lead_in  = s2_lead_ff;
      s2_tail_in  = s2_tail_ff;
      s2_zero_in  = s2_zero_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
         s2_op_in    = s1_op_ff;
         s2_data_in  = s1_data_ff;
         s2_lead_in  = lead_zeros(s1_data_ff);
         s2_tail_in  = lead_zeros(bit_rev(s1_data_ff));
         s2_zero_in  = (s1_data_ff == '0);
      end
   end

   // bit group assembly and stored count compare
   assign aligned     = s2_data_ff << s2_lead_ff;
   assign mlen        = LEN_W'(SAMPLE_W) - {1'b0, s2_lead_ff} - {1'b0, s2_tail_ff};
   assign same_counts = (s2_lead_ff == prev_lead_ff) && (s2_tail_ff == prev_trail_ff);
   assign new_counts  = s2_move && (s2_op_ff == OP_BITS) && !s2_zero_ff;
   assign q_push      = s2_move;

   always_comb begin
      q_item.op     = s2_op_ff;
      q_item.chunk  = '0;
      q_item.nbits  = '0;
      prev_lead_in  = new_counts ? s2_lead_ff : prev_lead_ff;
      prev_trail_in = new_counts ? s2_tail_ff : prev_trail_ff;
      case (s2_op_ff)
         OP_RAW: begin
            q_item.chunk = {s2_data_ff, PAD_W'(0)};
            q_item.nbits = LEN_W'(SAMPLE_W);
         end
         OP_BITS: begin
            if (s2_zero_ff) begin
               q_item.nbits = LEN_W'(1);
            end else if (same_counts) begin
               q_item.chunk = {CTL_SAME, aligned, (2 * CNT_W)'(0)};
               q_item.nbits = mlen + LEN_W'(2);
            end else begin
               q_item.chunk = {CTL_NEW, s2_lead_ff, s2_tail_ff, aligned};
               q_item.nbits = mlen + LEN_W'(2 + 2 * CNT_W);
            end
         end
         default: begin
            q_item.nbits = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         prev_sample_ff <= '0;
         prev_lead_ff   <= '0;
         prev_trail_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         started_ff     <= started_in;
         prev_sample_ff <= prev_sample_in;
         prev_lead_ff   <= prev_lead_in;
         prev_trail_ff  <= prev_trail_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_data_ff <= s1_data_in;
      s2_op_ff   <= s2_op_in;
      s2_data_ff <= s2_data_in;
      s2_lead_ff <= s2_lead_in;
      s2_tail_ff <= s2_tail_in;
      s2_zero_ff <= s2_zero_in;
   end

`ifndef SYNTHESIS
   // a nonzero xor never has more than 63 zeros between both ends
   a_counts_fit: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_op_ff == OP_BITS) && !s2_zero_ff) |->
      (({1'b0, s2_lead_ff} + {1'b0, s2_tail_ff}) < LEN_W'(SAMPLE_W)))
      else $error("zero counts exceed sample width");
`endif

endmodule

// ===== design/xves_queue.sv =====
// short request queue between front end and packer
module xves_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  xves_pkg::item_type  wr_item,
   input  logic                q_pop,
   output xves_pkg::item_type  rd_item,
   output xves_pkg::qstat_type q_stat
);
   import xves_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_item      = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(q_push) - (QPTR_W + 1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef SYNTHESIS
   // front end never writes into a full queue, back never pops an empty one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (q_push |-> !q_stat.full) and (q_pop |-> !q_stat.empty))
      else $error("queue overrun or underrun");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// ===== design/xves_back.sv =====
// back end: bit packer and result register
module xves_back (
   input  logic                          clock,
   input  logic                          reset,
   input  xves_pkg::item_type            rd_item,
   input  xves_pkg::qstat_type           q_stat,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [xves_pkg::SAMPLE_W-1:0] rsp_packed_word,
   output logic [xves_pkg::BITS_W-1:0]   rsp_word_bits,
   output logic                          rsp_kind,
   output logic                          rsp_last
);
   import xves_pkg::*;

   localparam int MERGE_W = SAMPLE_W + CHUNK_W;
   localparam int SPILL_W = CHUNK_W - SAMPLE_W;
   localparam int TOT_W   = 8;

   logic [SAMPLE_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                pend_ff, pend_in;
   logic [SPILL_W-1:0]  spill_ff, spill_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_word_ff, rsp_word_in;
   logic [BITS_W-1:0]   rsp_bits_ff, rsp_bits_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, emit;
   logic [MERGE_W-1:0]  merged;
   logic [TOT_W-1:0]    total;

   // append the head group right after the buffered bits
   assign merged = {buf_ff, CHUNK_W'(0)} | ({rd_item.chunk, SAMPLE_W'(0)} >> fill_ff);
   assign total  = TOT_W'(fill_ff) + TOT_W'(rd_item.nbits);

   assign out_free = !rsp_valid_ff || rsp_pop;

   // packer step
   always_comb begin
      buf_in      = buf_ff;
      fill_in     = fill_ff;
      pend_in     = pend_ff;
      spill_in    = spill_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      rsp_word_in = rsp_word_ff;
      rsp_bits_in = rsp_bits_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      if (out_free) begin
         if (pend_ff) begin
            // second full word of a long group
            emit        = 1'b1;
            rsp_word_in = buf_ff;
            rsp_bits_in = BITS_W'(WORD_BITS);
            rsp_kind_in = 1'b0;
            rsp_last_in = 1'b1;
            buf_in      = {spill_ff, (SAMPLE_W - SPILL_W)'(0)};
            pend_in     = 1'b0;
            q_pop       = 1'b1;
         end else if (!q_stat.empty) begin
            case (rd_item.op)
               OP_FLUSH: begin
                  q_pop = 1'b1;
                  if (fill_ff != '0) begin
                     emit        = 1'b1;
                     rsp_word_in = buf_ff;
                     rsp_bits_in = BITS_W'(fill_ff);
                     rsp_kind_in = 1'b0;
                     rsp_last_in = 1'b1;
                     buf_in      = '0;
                     fill_in     = '0;
                  end
               end
               OP_RAW: begin
                  q_pop       = 1'b1;
                  emit        = 1'b1;
                  rsp_word_in = rd_item.chunk[CHUNK_W-1 -: SAMPLE_W];
                  rsp_bits_in = BITS_W'(SAMPLE_W);
                  rsp_kind_in = 1'b1;
                  rsp_last_in = 1'b1;
               end
               OP_BITS: begin
                  fill_in = total[CNT_W-1:0];
                  if (total >= TOT_W'(2 * WORD_BITS)) begin
                     emit        = 1'b1;
                     rsp_word_in = merged[MERGE_W-1 -: SAMPLE_W];
                     rsp_bits_in = BITS_W'(WORD_BITS);
                     rsp_kind_in = 1'b0;
                     rsp_last_in = 1'b0;
                     buf_in      = merged[CHUNK_W-1 -: SAMPLE_W];
                     spill_in    = merged[SPILL_W-1:0];
                     pend_in     = 1'b1;
                  end else if (total >= TOT_W'(WORD_BITS)) begin
                     emit        = 1'b1;
                     rsp_word_in = merged[MERGE_W-1 -: SAMPLE_W];
                     rsp_bits_in = BITS_W'(WORD_BITS);
                     rsp_kind_in = 1'b0;
                     rsp_last_in = 1'b1;
                     buf_in      = merged[CHUNK_W-1 -: SAMPLE_W];
                     q_pop       = 1'b1;
                  end else begin
                     buf_in = merged[MERGE_W-1 -: SAMPLE_W];
                     q_pop  = 1'b1;
                  end
               end
               default: begin
                  q_pop = 1'b1;
               end
            endcase
         end
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_packed_word = rsp_word_ff;
   assign rsp_word_bits   = rsp_bits_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_last        = rsp_last_ff;

   // packer and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      spill_ff    <= spill_in;
      rsp_word_ff <= rsp_word_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // a pending second word follows a first word and keeps its request queued
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (rsp_valid_ff && !rsp_last_ff && !q_stat.empty))
      else $error("pending word without first word or request");
   // bits past the fill level stay clear so groups can be or-ed in
   a_clean_tail: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> ((buf_ff << fill_ff) == '0))
      else $error("packer buffer has stray bits past fill");
`endif

endmodule

// ===== dv/xor_value_stream_encoder_core_test.sv =====
// self-checking testbench for the xor value stream encoder core
module xor_value_stream_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import xves_pkg::*;

   localparam int REQ_COUNT    = 1500;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;

   // result kind codes
   localparam logic KIND_STREAM = 1'b0;
   localparam logic KIND_RAW    = 1'b1;

   // one result word as it should leave the block
   typedef struct {
      logic [SAMPLE_W-1:0] word;
      logic [BITS_W-1:0]   nbits;
      logic                kind;
      logic                last;
   } stream_word_type;

   // tracks encoder state and the words it owes
   class stream_scoreboard;
      stream_word_type     owed_words[$];
      bit                  started     = 0;
      logic [SAMPLE_W-1:0] prev_sample = '0;
      int unsigned         prev_lead   = 0;
      int unsigned         prev_trail  = 0;
      logic [WORD_BITS-1:0] pack_buf   = '0;
      int unsigned         pack_fill   = 0;
      int unsigned         mismatches  = 0;
      int unsigned         words_seen  = 0;
      int unsigned         flushes     = 0;
      int unsigned         repeats     = 0;
      int unsigned         reused_win  = 0;
      int unsigned         new_win     = 0;

      function void add_word(logic [SAMPLE_W-1:0] word, int unsigned nbits, logic kind);
         stream_word_type w;
         w.word  = word;
         w.nbits = BITS_W'(nbits);
         w.kind  = kind;
         w.last  = 1'b0;
         owed_words.push_back(w);
      endfunction

      // append the low n bits, msb first, emitting full words
      function void put_bits(logic [SAMPLE_W-1:0] bits, int unsigned n);
         for (int i = n; i > 0; i--) begin
            pack_buf[WORD_BITS-1-pack_fill] = bits[i-1];
            pack_fill++;
            if (pack_fill >= WORD_BITS) begin
               add_word(pack_buf, WORD_BITS, KIND_STREAM);
               pack_buf  = '0;
               pack_fill = 0;
            end
         end
      endfunction

      // predict the words caused by one accepted request
      function void note_request(logic [SAMPLE_W-1:0] value, logic flush);
         int unsigned         old_size;
         int unsigned         lead;
         int unsigned         trail;
         logic [SAMPLE_W-1:0] diff;
         old_size = owed_words.size();
         if (flush) begin
            flushes++;
            // an empty word gives nothing
            if (pack_fill != 0) begin
               add_word(pack_buf, pack_fill, KIND_STREAM);
               pack_buf  = '0;
               pack_fill = 0;
            end
         end else if (!started) begin
            started     = 1;
            prev_sample = value;
            add_word(value, SAMPLE_W, KIND_RAW);
         end else begin
            diff = prev_sample ^ value;
            if (diff == '0) begin
               // repeated sample: single zero bit, history untouched
               repeats++;
               put_bits('0, 1);
            end else begin
               lead = 0;
               while (!diff[SAMPLE_W-1-lead]) lead++;
               trail = 0;
               while (!diff[trail]) trail++;
               put_bits(1, 1);
               if (lead == prev_lead && trail == prev_trail) begin
                  reused_win++;
                  put_bits(0, 1);
               end else begin
                  new_win++;
                  put_bits(1, 1);
                  put_bits(lead, CNT_W);
                  put_bits(trail, CNT_W);
               end
               put_bits(diff >> trail, SAMPLE_W - lead - trail);
               prev_sample = value;
               prev_lead   = lead;
               prev_trail  = trail;
            end
         end
         if (owed_words.size() > old_size) owed_words[owed_words.size()-1].last = 1'b1;
      endfunction

      // compare one popped result with the oldest owed word
      function void check_result(logic [SAMPLE_W-1:0] word, logic [BITS_W-1:0] nbits,
                                 logic kind, logic last);
         stream_word_type want;
         if (owed_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: word %h bits %0d kind %0b last %0b",
                        word, nbits, kind, last);
            return;
         end
         want = owed_words.pop_front();
         words_seen++;
         if (want.word !== word || want.nbits !== nbits || want.kind !== kind ||
             want.last !== last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("result %0d mismatch: expected word %h bits %0d kind %0b last %0b",
                        words_seen, want.word, want.nbits, want.kind, want.last);
               $display("                      actual word %h bits %0d kind %0b last %0b",
                        word, nbits, kind, last);
            end
         end
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_push  = 1'b0;
   logic                req_full;
   logic [SAMPLE_W-1:0] req_value = '0;
   logic                req_flush = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop   = 1'b0;
   logic [SAMPLE_W-1:0] rsp_packed_word;
   logic [BITS_W-1:0]   rsp_word_bits;
   logic                rsp_kind;
   logic                rsp_last;

   stream_scoreboard    board = new;

   int unsigned         burst_left   = 0;
   logic [SAMPLE_W-1:0] last_sample  = '0;
   int unsigned         win_lead     = 0;
   int unsigned         win_trail    = 0;
   bit                  hold_request = 0;
   int unsigned         idle_cycles  = 0;
   int unsigned         full_cycles  = 0;

   xor_value_stream_encoder_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_flush       (req_flush),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_word (rsp_packed_word),
      .rsp_word_bits   (rsp_word_bits),
      .rsp_kind        (rsp_kind),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_full) full_cycles++;
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still owed",
                     IDLE_LIMIT, board.owed_words.size());
            $display("xor_value_stream_encoder_core_test: done, errors");
            $finish;
         end
      end
   end

   // offer one request, in bursts with random gaps between them
   task automatic offer(input logic [SAMPLE_W-1:0] value, input logic flush);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_push  <= 1'b1;
      req_value <= value;
      req_flush <= flush;
      do @(posedge clock); while (req_full);
      board.note_request(value, flush);
   endtask

   task automatic send_xor(input logic [SAMPLE_W-1:0] mask);
      last_sample = last_sample ^ mask;
      offer(last_sample, 1'b0);
   endtask

   // random xor pattern spanning exactly the given zero counts
   function automatic logic [SAMPLE_W-1:0] window_mask(int unsigned lead, int unsigned trail);
      logic [SAMPLE_W-1:0] m;
      m = {$urandom, $urandom} & (~64'd0 >> lead) & (~64'd0 << trail);
      m[SAMPLE_W-1-lead] = 1'b1;
      m[trail]           = 1'b1;
      return m;
   endfunction

   // request side: reset, directed cases, random stream
   initial begin
      int unsigned pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // flush before any sample, then raw first sample
      offer({$urandom, $urandom}, 1'b1);
      last_sample = '1;
      offer(last_sample, 1'b0);
      // full-width xor matches the zero counts held after reset
      send_xor('1);
      send_xor('0);
      // single bit at the top, twice to reuse the counts
      send_xor(64'h8000_0000_0000_0000);
      send_xor(64'h8000_0000_0000_0000);
      // single bit at the bottom
      send_xor(64'h0000_0000_0000_0001);
      // partial word, then an empty flush
      offer({$urandom, $urandom}, 1'b1);
      offer({$urandom, $urandom}, 1'b1);
      send_xor(64'h00FF_0000_0000_0000);
      send_xor(64'h0081_0000_0000_0000);
      // longest groups, new counts then reused counts
      send_xor('1);
      send_xor(64'h8000_0000_0000_0001);
      send_xor(64'h8000_0000_0000_0001);
      send_xor(64'h5555_5555_5555_5555);
      send_xor(64'hAAAA_AAAA_AAAA_AAAA);
      offer({$urandom, $urandom}, 1'b1);

      // random stream, mostly xor windows built to reuse or change the counts
      for (int i = 0; i < REQ_COUNT; i++) begin
         if (i == REQ_COUNT / 4) hold_request = 1;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            offer({$urandom, $urandom}, 1'b1);
         end else if (pick < 14) begin
            send_xor('0);
         end else if (pick < 18) begin
            last_sample = {$urandom, $urandom};
            offer(last_sample, 1'b0);
         end else if (pick < 50) begin
            send_xor(window_mask(win_lead, win_trail));
         end else begin
            win_lead  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 63);
            win_trail = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 63 - win_lead);
            send_xor(window_mask(win_lead, win_trail));
         end
      end
      offer({$urandom, $urandom}, 1'b1);
      req_push <= 1'b0;

      // drain, then watch for stray words
      while (board.owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d flushes, %0d repeated samples, %0d reused and %0d new windows",
               board.flushes, board.repeats, board.reused_win, board.new_win);
      $display("checked %0d result words, input held off %0d cycles, %0d mismatches",
               board.words_seen, full_cycles, board.mismatches);
      if (board.mismatches == 0) begin
         $display("xor_value_stream_encoder_core_test: done, clean");
      end else begin
         $display("xor_value_stream_encoder_core_test: done, errors");
      end
      $finish;
   end

   // result side: check popped words, stall on changing patterns
   initial begin
      int unsigned phase_left;
      int unsigned mode;
      logic [15:0] pattern;
      phase_left = 0;
      mode       = 0;
      pattern    = '1;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            board.check_result(rsp_packed_word, rsp_word_bits, rsp_kind, rsp_last);
         // one long hold-off so the queue fills and the input stalls
         if (hold_request) begin
            hold_request = 0;
            rsp_pop <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 2);
            pattern    = 16'($urandom) | 16'h0001;
            phase_left = $urandom_range(20, 80);
         end
         phase_left--;
         case (mode)
            0: begin
               rsp_pop <= 1'b1;
            end
            1: begin
               rsp_pop <= pattern[0];
               pattern = {pattern[0], pattern[15:1]};
            end
            default: begin
               rsp_pop <= ($urandom_range(0, 2) != 0);
            end
         endcase
      end
   end

endmodule
